FILE: design/rfst_pkg.sv
// Shared constants, types and saturating helpers for the rest-frame shear tensor block.
`default_nettype none

package rfst_pkg;

  // internal datapath word
  localparam int ACC_BITS = 64;
  localparam int HALF_BITS = ACC_BITS / 2;

  // default port word and fraction widths
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // multiplier pipeline depth, divider bits resolved per stage
  localparam int MUL_LAT = 5;
  localparam int DIV_STEP = 2;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // value plus saturation flag
  typedef struct packed {
    logic signed [ACC_BITS-1:0] v;
    logic                       c;
  } sat_t;

  function automatic sat_t sat_add(input logic signed [ACC_BITS-1:0] a,
                                   input logic signed [ACC_BITS-1:0] b);
    logic signed [ACC_BITS:0] s;
    sat_t r;
    s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      r.v = s[ACC_BITS] ? ACC_MIN : ACC_MAX;
      r.c = 1'b1;
    end else begin
      r.v = s[ACC_BITS-1:0];
      r.c = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t sat_sub(input logic signed [ACC_BITS-1:0] a,
                                   input logic signed [ACC_BITS-1:0] b);
    logic signed [ACC_BITS:0] s;
    sat_t r;
    s = {a[ACC_BITS-1], a} - {b[ACC_BITS-1], b};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      r.v = s[ACC_BITS] ? ACC_MIN : ACC_MAX;
      r.c = 1'b1;
    end else begin
      r.v = s[ACC_BITS-1:0];
      r.c = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/rfst_mul.sv
// Pipelined saturating fixed-point multiplier, rounded half away from zero.
`default_nettype none

module rfst_mul #(
  parameter int FRAC_BITS = rfst_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [rfst_pkg::ACC_BITS-1:0] a,
  input  logic signed [rfst_pkg::ACC_BITS-1:0] b,
  output logic signed [rfst_pkg::ACC_BITS-1:0] p,
  output logic                                 clip
);
  import rfst_pkg::*;

  localparam int PW = 2 * ACC_BITS;

  logic                s1_neg;
  logic [ACC_BITS-1:0] s1_ma, s1_mb;
  logic                s2_neg;
  logic [ACC_BITS-1:0] s2_ll, s2_lh, s2_hl, s2_hh;
  logic                s3_neg;
  logic [ACC_BITS:0]   s3_mid;
  logic [ACC_BITS-1:0] s3_ll, s3_hh;
  logic                s4_neg;
  logic [PW-1:0]       s4_prod;
  logic [PW-1:0]       rnd, mag;
  logic                ovf;

  // stage 1: sign and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg <= a[ACC_BITS-1] ^ b[ACC_BITS-1];
      s1_ma  <= a[ACC_BITS-1] ? ACC_BITS'(-a) : ACC_BITS'(a);
      s1_mb  <= b[ACC_BITS-1] ? ACC_BITS'(-b) : ACC_BITS'(b);
    end
  end

  // stage 2: four half-word partial products
  always_ff @(posedge clk) begin
    if (en) begin
      s2_neg <= s1_neg;
      s2_ll  <= s1_ma[HALF_BITS-1:0] * s1_mb[HALF_BITS-1:0];
      s2_lh  <= s1_ma[HALF_BITS-1:0] * s1_mb[ACC_BITS-1:HALF_BITS];
      s2_hl  <= s1_ma[ACC_BITS-1:HALF_BITS] * s1_mb[HALF_BITS-1:0];
      s2_hh  <= s1_ma[ACC_BITS-1:HALF_BITS] * s1_mb[ACC_BITS-1:HALF_BITS];
    end
  end

  // stage 3: middle terms
  always_ff @(posedge clk) begin
    if (en) begin
      s3_neg <= s2_neg;
      s3_mid <= {1'b0, s2_lh} + {1'b0, s2_hl};
      s3_ll  <= s2_ll;
      s3_hh  <= s2_hh;
    end
  end

  // stage 4: full product
  always_ff @(posedge clk) begin
    if (en) begin
      s4_neg  <= s3_neg;
      s4_prod <= {s3_hh, s3_ll} + (PW'(s3_mid) << HALF_BITS);
    end
  end

  // stage 5: round, scale and saturate
  always_comb begin
    rnd = s4_prod + (PW'(1) << (FRAC_BITS - 1));
    mag = rnd >> FRAC_BITS;
    ovf = (|mag[PW-1:ACC_BITS]) ||
          (mag[ACC_BITS-1] && (!s4_neg || (|mag[ACC_BITS-2:0])));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip <= ovf;
      if (ovf) begin
        p <= s4_neg ? ACC_MIN : ACC_MAX;
      end else begin
        p <= s4_neg ? -$signed(mag[ACC_BITS-1:0]) : $signed(mag[ACC_BITS-1:0]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/rfst_div.sv
// Pipelined restoring divider: a * 2^FRAC_BITS / d rounded, for positive d.
`default_nettype none

module rfst_div #(
  parameter int FRAC_BITS = rfst_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [rfst_pkg::ACC_BITS-1:0] a,
  input  logic signed [rfst_pkg::ACC_BITS-1:0] d,
  output logic signed [rfst_pkg::ACC_BITS-1:0] q,
  output logic                                 clip
);
  import rfst_pkg::*;

  localparam int NW = ACC_BITS + FRAC_BITS;
  localparam int NS = (NW + DIV_STEP - 1) / DIV_STEP;
  localparam int NP = NS * DIV_STEP;

  // numerator shifts out the top while quotient bits shift in below
  logic [NP-1:0]       nq     [0:NS];
  logic [ACC_BITS-1:0] rem    [0:NS];
  logic [ACC_BITS-1:0] dv     [0:NS];
  logic                ng     [0:NS];
  logic [NP-1:0]       nq_next  [0:NS-1];
  logic [ACC_BITS-1:0] rem_next [0:NS-1];
  logic [ACC_BITS-1:0] mag_a;
  logic [ACC_BITS-1:0] du;
  logic [NP-1:0]       quo;
  logic                ovf;

  assign mag_a = a[ACC_BITS-1] ? ACC_BITS'(-a) : ACC_BITS'(a);
  assign du    = ACC_BITS'(d);

  // scaled numerator plus half the divisor for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      nq[0]  <= (NP'(mag_a) << FRAC_BITS) + NP'(du >> 1);
      rem[0] <= '0;
      dv[0]  <= du;
      ng[0]  <= a[ACC_BITS-1];
    end
  end

  // DIV_STEP quotient bits per stage
  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [NP-1:0]       n;
    logic [ACC_BITS-1:0] r, t;

    always_comb begin
      n = nq[g];
      r = rem[g];
      t = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
        t = {r[ACC_BITS-2:0], n[NP-1]};
        n = {n[NP-2:0], 1'b0};
        if (t >= dv[g]) begin
          r    = t - dv[g];
          n[0] = 1'b1;
        end else begin
          r = t;
        end
      end
      nq_next[g]  = n;
      rem_next[g] = r;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[g+1]  <= nq_next[g];
        rem[g+1] <= rem_next[g];
        dv[g+1]  <= dv[g];
        ng[g+1]  <= ng[g];
      end
    end
  end

  // sign and saturation
  always_comb begin
    quo = nq[NS];
    ovf = (|quo[NP-1:ACC_BITS]) ||
          (quo[ACC_BITS-1] && (!ng[NS] || (|quo[ACC_BITS-2:0])));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip <= ovf;
      if (ovf) begin
        q <= ng[NS] ? ACC_MIN : ACC_MAX;
      end else begin
        q <= ng[NS] ? -$signed(quo[ACC_BITS-1:0]) : $signed(quo[ACC_BITS-1:0]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/rest_frame_shear_tensor.sv
// Top level: boosts a symmetric shear tensor into the fluid rest frame, fully pipelined.
//
// Input stream (s_*): one word holds the six tensor entries pi_xx, pi_xy, pi_xz,
// pi_yy, pi_yz, pi_zz, then vel_t (unsigned, WORD_BITS-1 bits), vel_x, vel_y, vel_z,
// all fixed point with FRAC_BITS fraction bits. Output stream (m_*): one word per
// input word with the six rest-frame entries in tdata and the clipped flag in tuser.
// Throughput: one word per cycle while the output is not stalled. Items are
// independent, so every multiply and divide unit is a pipeline that takes a
// new operand each cycle. The two chained rounds of 80-bit restoring division
// at the default FRAC_BITS of 16 (two quotient bits per stage) make up most
// of the pipeline depth.
// Reset clears all valid bits and the output and skid valid flags; no words are
// held afterward. A vel_t below 1.0 is raised to 1.0.
// Stall: the result sits in the output register while m_tready is low; one
// more word lands in a skid register and the pipeline then freezes as a whole,
// dropping s_tready, until the receiver drains it. Nothing is lost or repeated.
`default_nettype none

module rest_frame_shear_tensor #(
  parameter int WORD_BITS = rfst_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rfst_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // pi_xx, pi_xy, pi_xz, pi_yy, pi_yz, pi_zz, vel_t, vel_x, vel_y, vel_z, zero fill
  input  logic [((10*WORD_BITS+6)/8)*8-1:0]       s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // rest_xx, rest_xy, rest_xz, rest_yy, rest_yz, rest_zz, zero fill
  output logic [((6*WORD_BITS+7)/8)*8-1:0]        m_tdata,
  // clipped
  output logic                                    m_tuser
);
  import rfst_pkg::*;

  localparam int TDO = ((6*WORD_BITS+7)/8)*8;
  localparam int DIV_LAT = (ACC_BITS + FRAC_BITS + DIV_STEP - 1) / DIV_STEP + 2;

  // pipeline time points
  localparam int T1 = MUL_LAT;
  localparam int TV = T1 + 2;
  localparam int T2 = TV + MUL_LAT;
  localparam int TC = T2 + 2;
  localparam int T3 = TC + MUL_LAT;
  localparam int T4 = T3 + DIV_LAT;
  localparam int T5 = T4 + MUL_LAT;
  localparam int T6 = T5 + DIV_LAT;
  localparam int TP = T2 + DIV_LAT;
  localparam int NT = T6 + 3;
  localparam int PJ = T6 + 1 - TP;

  // symmetric tensor positions and output entry indexes
  localparam int POS [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
  localparam int OUT_A [6] = '{0, 0, 0, 1, 1, 2};
  localparam int OUT_B [6] = '{0, 1, 2, 1, 2, 2};

  localparam logic signed [ACC_BITS-1:0] ONE = ACC_BITS'(1) << FRAC_BITS;
  localparam logic signed [ACC_BITS-1:0] X_MIN = ONE << 1;
  localparam logic signed [ACC_BITS-1:0] WMAX = (ACC_BITS'(1) << (WORD_BITS - 1)) - 1;
  localparam logic signed [ACC_BITS-1:0] WMIN = ~WMAX;

  // per-item values carried down the pipeline
  typedef struct packed {
    logic [5:0][WORD_BITS-1:0]  pi;
    logic [2:0][WORD_BITS-1:0]  u;
    logic signed [ACC_BITS-1:0] x;
    logic                       clip;
  } side_t;

  typedef struct packed {
    logic [5:0][WORD_BITS-1:0] rest;
    logic                      clipped;
  } res_t;

  logic                        en;
  logic                        skid_valid;
  res_t                        out_q, skid_q, res;
  logic                        vld       [0:NT];
  side_t                       side      [0:NT];
  side_t                       side_next [1:NT];
  logic signed [ACC_BITS-1:0]  r0_u0, r0_u0p1;
  logic [ACC_BITS-1:0]         vt;

  logic signed [ACC_BITS-1:0]  m1_p [3][3];
  logic [8:0]                  m1_c;
  logic signed [ACC_BITS-1:0]  x_p;
  logic                        x_c;
  sat_t                        a1a_s [3];
  sat_t                        a1b_s [3];
  logic [2:0]                  a1a_c, a1b_c;
  logic signed [ACC_BITS-1:0]  ta  [3];
  logic signed [ACC_BITS-1:0]  m2d [3];
  logic signed [ACC_BITS-1:0]  v   [3];
  logic signed [ACC_BITS-1:0]  w_p [3][3];
  logic [8:0]                  w_c;
  sat_t                        a2a_s, a2b_s;
  logic signed [ACC_BITS-1:0]  ca, w22d, c;
  logic signed [ACC_BITS-1:0]  m3_p [3];
  logic [2:0]                  m3_c;
  logic signed [ACC_BITS-1:0]  s_q  [3];
  logic [2:0]                  s_c;
  logic signed [ACC_BITS-1:0]  m4_p [6];
  logic [5:0]                  m4_c;
  logic signed [ACC_BITS-1:0]  q_q  [6];
  logic [5:0]                  q_c;
  logic [8:0][ACC_BITS-1:0]    p_now;
  logic [8:0]                  p_c;
  logic [8:0][ACC_BITS-1:0]    pline [1:PJ];
  sat_t                        f1_s [6];
  sat_t                        f2_s [6];
  sat_t                        f3_s [6];
  logic [5:0]                  f1_c, f2_c, f3_c, tw_c;
  logic signed [ACC_BITS-1:0]  r1 [6];
  logic signed [ACC_BITS-1:0]  r2 [6];
  logic signed [ACC_BITS-1:0]  r3 [6];
  logic signed [ACC_BITS-1:0]  qd1 [6];
  logic signed [ACC_BITS-1:0]  qd2 [6];

  // whole pipeline moves while the skid register is free
  assign en       = ~skid_valid;
  assign s_tready = ~skid_valid;

  // input stage: clamped u0 and 1 + u0
  assign vt = ACC_BITS'(s_tdata[6*WORD_BITS +: WORD_BITS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      r0_u0   <= ($signed(vt) < ONE) ? ONE : $signed(vt);
      r0_u0p1 <= (($signed(vt) < ONE) ? ONE : $signed(vt)) + ONE;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t <= NT; t++) begin
        vld[t] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int t = 1; t <= NT; t++) begin
        vld[t] <= vld[t-1];
      end
    end
  end

  // side line with x insertion and clip merges
  always_comb begin
    for (int t = 1; t <= NT; t++) begin
      side_next[t] = side[t-1];
      if (t == T1 + 1) begin
        side_next[t].x    = x_p;
        side_next[t].clip = side_next[t].clip | x_c | (|m1_c) | (|a1a_c);
      end
      if (t == TV) side_next[t].clip = side_next[t].clip | (|a1b_c);
      if (t == T2 + 1) side_next[t].clip = side_next[t].clip | (|w_c) | a2a_s.c;
      if (t == TC) side_next[t].clip = side_next[t].clip | a2b_s.c;
      if (t == T3 + 1) side_next[t].clip = side_next[t].clip | (|m3_c);
      if (t == T4 + 1) side_next[t].clip = side_next[t].clip | (|s_c);
      if (t == T5 + 1) side_next[t].clip = side_next[t].clip | (|m4_c);
      if (t == TP + 1) side_next[t].clip = side_next[t].clip | (|p_c);
      if (t == T6 + 1) side_next[t].clip = side_next[t].clip | (|q_c) | (|f1_c);
      if (t == T6 + 2) side_next[t].clip = side_next[t].clip | (|f2_c);
      if (t == NT) side_next[t].clip = side_next[t].clip | (|f3_c);
    end
  end

  // input word capture and side line shift
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        side[0].pi[k] <= s_tdata[k*WORD_BITS +: WORD_BITS];
      end
      for (int k = 0; k < 3; k++) begin
        side[0].u[k] <= s_tdata[(7*WORD_BITS-1) + k*WORD_BITS +: WORD_BITS];
      end
      side[0].x    <= '0;
      side[0].clip <= 1'b0;
      for (int t = 1; t <= NT; t++) begin
        side[t] <= side_next[t];
      end
    end
  end

  // pi products and x = u0 (1 + u0)
  for (genvar ga = 0; ga < 3; ga++) begin : g_m1a
    for (genvar gb = 0; gb < 3; gb++) begin : g_m1b
      rfst_mul #(.FRAC_BITS(FRAC_BITS)) u_m1 (
        .clk  (clk),
        .en   (en),
        .a    (ACC_BITS'($signed(side[0].pi[POS[ga][gb]]))),
        .b    (ACC_BITS'($signed(side[0].u[gb]))),
        .p    (m1_p[ga][gb]),
        .clip (m1_c[ga*3+gb])
      );
    end
  end

  rfst_mul #(.FRAC_BITS(FRAC_BITS)) u_mx (
    .clk  (clk),
    .en   (en),
    .a    (r0_u0),
    .b    (r0_u0p1),
    .p    (x_p),
    .clip (x_c)
  );

  // v = pi u, summed in two steps
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      a1a_s[a] = sat_add(m1_p[a][0], m1_p[a][1]);
      a1a_c[a] = a1a_s[a].c;
      a1b_s[a] = sat_add(ta[a], m2d[a]);
      a1b_c[a] = a1b_s[a].c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ta[a]  <= a1a_s[a].v;
        m2d[a] <= m1_p[a][2];
        v[a]   <= a1b_s[a].v;
      end
    end
  end

  // w_ab = u_a v_b; the diagonal also feeds c
  for (genvar ga = 0; ga < 3; ga++) begin : g_m2a
    for (genvar gb = 0; gb < 3; gb++) begin : g_m2b
      rfst_mul #(.FRAC_BITS(FRAC_BITS)) u_m2 (
        .clk  (clk),
        .en   (en),
        .a    (ACC_BITS'($signed(side[TV].u[ga]))),
        .b    (v[gb]),
        .p    (w_p[ga][gb]),
        .clip (w_c[ga*3+gb])
      );
    end
  end

  // c = u . v
  assign a2a_s = sat_add(w_p[0][0], w_p[1][1]);
  assign a2b_s = sat_add(ca, w22d);

  always_ff @(posedge clk) begin
    if (en) begin
      ca   <= a2a_s.v;
      w22d <= w_p[2][2];
      c    <= a2b_s.v;
    end
  end

  // p_ab = w_ab / x
  for (genvar ga = 0; ga < 3; ga++) begin : g_dpa
    for (genvar gb = 0; gb < 3; gb++) begin : g_dpb
      rfst_div #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk  (clk),
        .en   (en),
        .a    (w_p[ga][gb]),
        .d    (side[T2].x),
        .q    (p_now[ga*3+gb]),
        .clip (p_c[ga*3+gb])
      );
    end
  end

  // hold p until the q terms catch up
  always_ff @(posedge clk) begin
    if (en) begin
      pline[1] <= p_now;
      for (int j = 2; j <= PJ; j++) begin
        pline[j] <= pline[j-1];
      end
    end
  end

  // s_a = c u_a / x
  for (genvar ga = 0; ga < 3; ga++) begin : g_s
    logic signed [ACC_BITS-1:0] cu;

    rfst_mul #(.FRAC_BITS(FRAC_BITS)) u_m3 (
      .clk  (clk),
      .en   (en),
      .a    (c),
      .b    (ACC_BITS'($signed(side[TC].u[ga]))),
      .p    (cu),
      .clip (m3_c[ga])
    );

    assign m3_p[ga] = cu;

    rfst_div #(.FRAC_BITS(FRAC_BITS)) u_ds (
      .clk  (clk),
      .en   (en),
      .a    (m3_p[ga]),
      .d    (side[T3].x),
      .q    (s_q[ga]),
      .clip (s_c[ga])
    );
  end

  // q_ab = s_a u_b / x
  for (genvar gk = 0; gk < 6; gk++) begin : g_q
    rfst_mul #(.FRAC_BITS(FRAC_BITS)) u_m4 (
      .clk  (clk),
      .en   (en),
      .a    (s_q[OUT_A[gk]]),
      .b    (ACC_BITS'($signed(side[T4].u[OUT_B[gk]]))),
      .p    (m4_p[gk]),
      .clip (m4_c[gk])
    );

    rfst_div #(.FRAC_BITS(FRAC_BITS)) u_dq (
      .clk  (clk),
      .en   (en),
      .a    (m4_p[gk]),
      .d    (side[T5].x),
      .q    (q_q[gk]),
      .clip (q_c[gk])
    );
  end

  // r = ((pi - p_ab) - p_ba) + q_ab, one step per stage
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      f1_s[k] = sat_sub(ACC_BITS'($signed(side[T6].pi[k])),
                        $signed(pline[T6-TP][OUT_A[k]*3+OUT_B[k]]));
      f1_c[k] = f1_s[k].c;
      f2_s[k] = sat_sub(r1[k], $signed(pline[T6+1-TP][OUT_B[k]*3+OUT_A[k]]));
      f2_c[k] = f2_s[k].c;
      f3_s[k] = sat_add(r2[k], qd2[k]);
      f3_c[k] = f3_s[k].c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        r1[k]  <= f1_s[k].v;
        qd1[k] <= q_q[k];
        r2[k]  <= f2_s[k].v;
        qd2[k] <= qd1[k];
        r3[k]  <= f3_s[k].v;
      end
    end
  end

  // clamp to the port word
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      tw_c[k] = 1'b0;
      if (r3[k] > WMAX) begin
        res.rest[k] = WMAX[WORD_BITS-1:0];
        tw_c[k]     = 1'b1;
      end else if (r3[k] < WMIN) begin
        res.rest[k] = WMIN[WORD_BITS-1:0];
        tw_c[k]     = 1'b1;
      end else begin
        res.rest[k] = r3[k][WORD_BITS-1:0];
      end
    end
    res.clipped = side[NT].clip | (|tw_c);
  end

  // output register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (m_tvalid && !m_tready) begin
        if (vld[NT]) begin
          skid_valid <= 1'b1;
          skid_q     <= res;
        end
      end else begin
        m_tvalid <= vld[NT];
        out_q    <= res;
      end
    end else if (m_tready) begin
      out_q      <= skid_q;
      skid_valid <= 1'b0;
    end
  end

  assign m_tdata = TDO'(out_q.rest);
  assign m_tuser = out_q.clipped;

  // skid holds a word only behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register full while output register empty");

  // skid fills only when the receiver stalled a waiting word
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid register loaded without a stall");

  // clamped u0 keeps the divisor at two or more
  a_x_floor: assert property (@(posedge clk) disable iff (rst)
    vld[T2] |-> (side[T2].x >= X_MIN))
    else $error("divisor x below 2.0");

endmodule

`default_nettype wire

FILE: verif/rest_frame_shear_tensor_checker.sv
// Checker for the rest-frame shear tensor block: predicts each output word and compares it.
`default_nettype none

module rest_frame_shear_tensor_checker #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int IN_BITS = ((10*WORD_BITS+6)/8)*8,
  parameter int OUT_BITS = ((6*WORD_BITS+7)/8)*8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OUT_BITS-1:0] m_tdata,
  input  logic                m_tuser,
  output int                  fail_count,
  output int                  pending,
  output int                  words_checked,
  output int                  clip_count
);

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FRAC_BITS;

  typedef struct {
    logic [6*WORD_BITS-1:0] tensor;
    logic                   clip;
  } rest_word_t;

  rest_word_t rest_fifo[$];
  bit clip_seen;

  // clamp a wide signed value to 64 bits
  function automatic logic signed [63:0] clamp64(input logic signed [129:0] w);
    if (w > 130'(S64_MAX)) begin
      clip_seen = 1;
      return S64_MAX;
    end
    if (w < 130'(S64_MIN)) begin
      clip_seen = 1;
      return S64_MIN;
    end
    return w[63:0];
  endfunction

  // unsigned magnitude of a signed 64-bit value
  function automatic logic [63:0] magn(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // product with magnitude rounded half away from zero
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic [129:0] m;
    logic neg;
    neg = a[63] ^ b[63];
    m = 130'(magn(a)) * 130'(magn(b));
    m = (m + (130'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
    return clamp64(neg ? -$signed(m) : $signed(m));
  endfunction

  // quotient with magnitude rounded to nearest, ties away; den > 0
  function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
                                                input logic signed [63:0] den);
    logic [129:0] m;
    m = 130'(magn(a));
    m = ((m << FRAC_BITS) + 130'(den >> 1)) / 130'(den);
    return clamp64(a[63] ? -$signed(m) : $signed(m));
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return clamp64(130'(a) + 130'(b));
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return clamp64(130'(a) - 130'(b));
  endfunction

  function automatic rest_word_t boost_to_rest(input logic [IN_BITS-1:0] d);
    logic signed [63:0] pi[6], u[3], v[3], s[3];
    logic signed [63:0] u0, c, x, pab, pba, q, r;
    logic signed [63:0] wmax, wmin;
    int ent[3][3];
    int ra[6], rb[6];
    rest_word_t res;
    ent = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
    ra = '{0, 0, 0, 1, 1, 2};
    rb = '{0, 1, 2, 1, 2, 2};
    wmax = (64'sd1 <<< (WORD_BITS-1)) - 1;
    wmin = -wmax - 1;
    clip_seen = 0;
    for (int k = 0; k < 6; k++)
      pi[k] = 64'(signed'(d[k*WORD_BITS +: WORD_BITS]));
    u0 = 64'(d[6*WORD_BITS +: WORD_BITS-1]);
    if (u0 < FX_ONE) u0 = FX_ONE;
    // vel_t is one bit short, so the spatial parts start one bit lower
    for (int k = 0; k < 3; k++)
      u[k] = 64'(signed'(d[(7*WORD_BITS-1) + k*WORD_BITS +: WORD_BITS]));
    c = 0;
    for (int a = 0; a < 3; a++) begin
      v[a] = 0;
      for (int b = 0; b < 3; b++) v[a] = sadd(v[a], fx_mul(pi[ent[a][b]], u[b]));
    end
    for (int a = 0; a < 3; a++) c = sadd(c, fx_mul(v[a], u[a]));
    x = fx_mul(u0, FX_ONE + u0);
    for (int a = 0; a < 3; a++) s[a] = fx_div(fx_mul(c, u[a]), x);
    for (int k = 0; k < 6; k++) begin
      pab = fx_div(fx_mul(u[ra[k]], v[rb[k]]), x);
      pba = fx_div(fx_mul(u[rb[k]], v[ra[k]]), x);
      q = fx_div(fx_mul(s[ra[k]], u[rb[k]]), x);
      r = sadd(ssub(ssub(pi[k], pab), pba), q);
      if (r > wmax) begin
        clip_seen = 1;
        r = wmax;
      end
      if (r < wmin) begin
        clip_seen = 1;
        r = wmin;
      end
      res.tensor[k*WORD_BITS +: WORD_BITS] = r[WORD_BITS-1:0];
    end
    res.clip = clip_seen;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [255:0] got,
                                 input logic [255:0] want);
    $display("mismatch word %0d %s: got %h want %h", words_checked, what, got, want);
    fail_count++;
  endtask

  assign pending = rest_fifo.size();

  // predict on input words, compare on output words
  always @(posedge clk) begin
    rest_word_t want;
    if (rst) begin
      fail_count <= 0;
      words_checked <= 0;
      clip_count <= 0;
    end else begin
      if (s_tvalid && s_tready) rest_fifo = {rest_fifo, boost_to_rest(s_tdata)};
      if (m_tvalid && m_tready) begin
        if (rest_fifo.size() == 0) begin
          report_mismatch("unexpected word", m_tdata, 0);
        end else begin
          want = rest_fifo.pop_front();
          for (int k = 0; k < 6; k++)
            if (m_tdata[k*WORD_BITS +: WORD_BITS] !== want.tensor[k*WORD_BITS +: WORD_BITS])
              report_mismatch($sformatf("entry %0d", k), m_tdata[k*WORD_BITS +: WORD_BITS],
                              want.tensor[k*WORD_BITS +: WORD_BITS]);
          if (m_tuser !== want.clip) report_mismatch("clipped", m_tuser, want.clip);
          if (want.clip) clip_count <= clip_count + 1;
        end
        words_checked <= words_checked + 1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: verif/rest_frame_shear_tensor_tb.sv
// Testbench top: drives the tensor stream, stalls the output, and reports the verdict.
`default_nettype none

module rest_frame_shear_tensor_tb;

  localparam int WB = rfst_pkg::WORD_BITS_DEF;
  localparam int FB = rfst_pkg::FRAC_BITS_DEF;
  localparam int IN_BITS = ((10*WB+6)/8)*8;
  localparam int OUT_BITS = ((6*WB+7)/8)*8;
  localparam int LATENCY = 112;
  localparam int N_RANDOM = 1330;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_BITS-1:0] m_tdata;
  logic m_tuser;
  int fail_count, pending, words_checked, clip_count;
  bit stim_done = 0;

  rest_frame_shear_tensor i_dut (.*);

  rest_frame_shear_tensor_checker #(.WORD_BITS(WB), .FRAC_BITS(FB)) i_check (.*);

  initial forever #5 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

  // one word: six tensor entries then vel_t, vel_x, vel_y, vel_z, packed gap-free
  task automatic send_word(input logic [WB-1:0] pi[6], input logic [WB-2:0] vt,
                           input logic [WB-1:0] vx, input logic [WB-1:0] vy,
                           input logic [WB-1:0] vz);
    int gap;
    logic [IN_BITS-1:0] word;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    word = '0;
    for (int k = 0; k < 6; k++) word[k*WB +: WB] = pi[k];
    word[6*WB +: WB-1] = vt;
    word[7*WB-1 +: WB] = vx;
    word[8*WB-1 +: WB] = vy;
    word[9*WB-1 +: WB] = vz;
    s_tdata <= word;
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // small physical-ish value in Q15.16, or a raw extreme now and then
  function automatic logic [WB-1:0] pick(input int scale);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return {1'b1, {(WB-1){1'b0}}};
      2: return {1'b0, {(WB-1){1'b1}}};
      default: return WB'(signed'($urandom_range(0, 2*scale) - scale));
    endcase
  endfunction

  // receiver stalls
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [WB-1:0] pi[6];
    logic [WB-1:0] vmin, vmax;
    int waited;
    vmin = {1'b1, {(WB-1){1'b0}}};
    vmax = {1'b0, {(WB-1){1'b1}}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: zeros, at rest, vel_t below one, extremes, all bits
    pi = '{default: 0};
    send_word(pi, 0, 0, 0, 0);
    pi = '{32'h10000, 32'h8000, 32'hFFFF0000, 32'h20000, 0, 32'hFFFE0000};
    send_word(pi, 31'h10000, 0, 0, 0);
    send_word(pi, 31'h8000, 32'h10000, 0, 0);
    send_word(pi, 31'h1, 0, 32'h4000, 32'hFFFFC000);
    send_word(pi, 31'h18000, 32'h8000, 32'h8000, 32'h8000);
    send_word(pi, 31'h30000, 32'hFFFE0000, 32'h18000, 32'h20000);
    pi = '{default: vmax};
    send_word(pi, 31'h10000, vmax, vmax, vmax);
    send_word(pi, {(WB-1){1'b1}}, vmax, vmax, vmax);
    pi = '{default: vmin};
    send_word(pi, 31'h10000, vmin, vmin, vmin);
    send_word(pi, {(WB-1){1'b1}}, vmin, vmax, vmin);
    pi = '{default: 32'hFFFFFFFF};
    send_word(pi, {(WB-1){1'b1}}, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    pi = '{vmax, vmin, vmax, vmin, vmax, vmin};
    send_word(pi, 31'h7FFF0000, 32'h10000, vmin, 32'h7FFF0000);
    pi = '{32'h640000, 0, 0, 32'h640000, 0, 32'h640000};
    send_word(pi, 31'h20000, 32'h1BB67, 0, 0);
    send_word(pi, 31'h1000000, 32'hFF000, 32'hFF000, 32'hFF000);

    // random: mostly modest velocities, sometimes huge ones
    for (int n = 0; n < N_RANDOM; n++) begin
      int vs;
      vs = ($urandom_range(0, 7) == 0) ? 32'h7FFFFFFF : (32'h10000 << $urandom_range(0, 6));
      for (int k = 0; k < 6; k++) pi[k] = pick(32'h10000 << $urandom_range(0, 10));
      send_word(pi, ($urandom_range(0, 9) == 0) ? 31'($urandom)
                      : 31'(32'h10000 + $urandom_range(0, vs)),
                pick(vs / 2), pick(vs / 2), pick(vs / 2));
    end
    s_tvalid <= 0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    $display("checked %0d result words, %0d with clipping", words_checked, clip_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
